// ===== src/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int unsigned ELEM_W   = 16;  // Q8.8 input element
  localparam int unsigned PROD_W   = 32;  // element * element
  localparam int unsigned COF_W    = 33;  // cofactor, Q17.16
  localparam int unsigned DPROD_W  = 49;  // element * cofactor
  localparam int unsigned DET_W    = 50;  // determinant, Q26.24
  localparam int unsigned MAG_W    = 32;  // |cofactor|
  localparam int unsigned RES_W    = 32;  // Q16.16 result
  localparam int unsigned REM_W    = DET_W + 1;
  localparam int unsigned NSHIFT   = 24;  // numerator is |adj| << 24
  localparam int unsigned STEPS    = 4;   // quotient bits per divider stage
  localparam int unsigned DIV_STG  = RES_W / STEPS;
  localparam int unsigned NLANES   = 9;

  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef elem_t       [NLANES-1:0]  elem_arr_t;
  typedef logic signed [COF_W-1:0]   cof_t;
  typedef cof_t        [NLANES-1:0]  cof_arr_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef mag_t        [NLANES-1:0]  mag_arr_t;
  typedef logic signed [RES_W-1:0]   res_t;
  typedef res_t        [NLANES-1:0]  res_arr_t;

  // Cofactor k = m[A1]*m[A2] - m[B1]*m[B2], signs already folded in.
  localparam int unsigned CA1 [NLANES] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int unsigned CA2 [NLANES] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int unsigned CB1 [NLANES] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int unsigned CB2 [NLANES] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  localparam res_t RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam res_t RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== src/mi3_cofactor.sv =====
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the 18 minor products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_cofactor import mi3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  elem_arr_t m,
  output logic      out_vld,
  output cof_arr_t  cof,
  output elem_t     row0 [3]
);

  logic signed [PROD_W-1:0] pa_r [NLANES];
  logic signed [PROD_W-1:0] pb_r [NLANES];
  logic signed [PROD_W-1:0] pa_nxt [NLANES];
  logic signed [PROD_W-1:0] pb_nxt [NLANES];
  elem_t    r0a_r [3];
  elem_t    r0b_r [3];
  cof_arr_t cof_r, cof_nxt;
  logic     v1_r, v2_r;

  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      pa_nxt[k] = PROD_W'(m[4'(CA1[k])]) * PROD_W'(m[4'(CA2[k])]);
      pb_nxt[k] = PROD_W'(m[4'(CB1[k])]) * PROD_W'(m[4'(CB2[k])]);
    end
  end

  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      cof_nxt[k] = COF_W'(pa_r[k]) - COF_W'(pb_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      cof_r <= cof_nxt;
      for (int k = 0; k < 3; k++) begin
        r0a_r[k] <= m[4'(k)];
        r0b_r[k] <= r0a_r[k];
      end
    end
  end

  assign out_vld = v2_r;
  assign cof     = cof_r;
  assign row0    = r0b_r;

endmodule

`default_nettype wire

// ===== src/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det
// Two stages: first-row products, then determinant sum, magnitudes and signs
// of the transposed cofactors (adjugate) for the divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_det import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  cof_arr_t         cof,
  input  elem_t            row0 [3],
  output logic             out_vld,
  output logic [DET_W-1:0] det_mag,
  output logic             det_zero,
  output mag_arr_t         adj_mag,
  output logic [NLANES-1:0] adj_neg
);

  logic signed [DPROD_W-1:0] dp_r [3];
  cof_arr_t                  cof_r;
  logic                      v3_r, v4_r;
  logic signed [DET_W-1:0]   det;
  logic [DET_W-1:0]          dmag_r, dmag_nxt;
  logic                      dz_r, dz_nxt;
  mag_arr_t                  amag_r, amag_nxt;
  logic [NLANES-1:0]         aneg_r, aneg_nxt;
  cof_t                      c;

  always_comb begin
    det      = DET_W'(dp_r[0]) + DET_W'(dp_r[1]) + DET_W'(dp_r[2]);
    dmag_nxt = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    dz_nxt   = (det == '0);
    c        = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        c = cof_r[4'(k*3+i)];
        amag_nxt[4'(i*3+k)] = c[COF_W-1] ? MAG_W'(-c) : MAG_W'(c);
        aneg_nxt[4'(i*3+k)] = c[COF_W-1] ^ det[DET_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_vld;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dp_r[k] <= DPROD_W'(row0[k]) * DPROD_W'(cof[4'(k)]);
      end
      cof_r  <= cof;
      dmag_r <= dmag_nxt;
      dz_r   <= dz_nxt;
      amag_r <= amag_nxt;
      aneg_r <= aneg_nxt;
    end
  end

  assign out_vld  = v4_r;
  assign det_mag  = dmag_r;
  assign det_zero = dz_r;
  assign adj_mag  = amag_r;
  assign adj_neg  = aneg_r;

endmodule

`default_nettype wire

// ===== src/mi3_div_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider: (|adj| << 24) / |det|, four quotient bits
// per stage, then sign and 32-bit saturation in a final register.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div_lane import mi3_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DET_W-1:0] den,
  input  mag_t             amag,
  input  logic             neg,
  output res_t             quo,
  output logic             sat
);

  localparam int unsigned CMP_W = MAG_W + 8 + DET_W;

  logic [REM_W-1:0] rem_r [DIV_STG];
  logic [RES_W-1:0] nlo_r [DIV_STG];
  logic [RES_W-1:0] q_r   [DIV_STG];
  logic [DET_W-1:0] d_r   [DIV_STG];
  logic             neg_r [DIV_STG];
  logic             ovf_r [DIV_STG];
  res_t             quo_r;
  logic             sat_r;

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [REM_W-1:0] rem_i, rem_c;
    logic [RES_W-1:0] nlo_i, nlo_c, q_i, q_c;
    logic [DET_W-1:0] d_i;
    logic             neg_i, ovf_i;

    if (s == 0) begin : g_first
      // quotient fits 32 bits only if |adj| < |det| * 2^8
      assign rem_i = REM_W'(amag[MAG_W-1:MAG_W-NSHIFT]);
      assign nlo_i = {amag[MAG_W-NSHIFT-1:0], NSHIFT'(0)};
      assign q_i   = '0;
      assign d_i   = den;
      assign neg_i = neg;
      assign ovf_i = CMP_W'(amag) >= CMP_W'({den, 8'b0});
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign nlo_i = nlo_r[s-1];
      assign q_i   = q_r[s-1];
      assign d_i   = d_r[s-1];
      assign neg_i = neg_r[s-1];
      assign ovf_i = ovf_r[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] t;
      rem_c = rem_i;
      nlo_c = nlo_i;
      q_c   = q_i;
      t     = '0;
      for (int j = 0; j < STEPS; j++) begin
        t     = {rem_c[REM_W-2:0], nlo_c[RES_W-1]};
        nlo_c = {nlo_c[RES_W-2:0], 1'b0};
        if (t >= REM_W'(d_i)) begin
          t   = t - REM_W'(d_i);
          q_c = {q_c[RES_W-2:0], 1'b1};
        end else begin
          q_c = {q_c[RES_W-2:0], 1'b0};
        end
        rem_c = t;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        nlo_r[s] <= nlo_c;
        q_r[s]   <= q_c;
        d_r[s]   <= d_i;
        neg_r[s] <= neg_i;
        ovf_r[s] <= ovf_i;
      end
    end
  end

  logic [RES_W-1:0] mag;
  logic             sat_nxt;
  res_t             quo_nxt;

  always_comb begin
    mag     = q_r[DIV_STG-1];
    sat_nxt = ovf_r[DIV_STG-1]
            | (!neg_r[DIV_STG-1] & mag[RES_W-1])
            | (neg_r[DIV_STG-1] & mag[RES_W-1] & (|mag[RES_W-2:0]));
    if (sat_nxt) begin
      quo_nxt = neg_r[DIV_STG-1] ? RES_MIN : RES_MAX;
    end else begin
      quo_nxt = neg_r[DIV_STG-1] ? res_t'(-mag) : res_t'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

// ===== src/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Streaming 3x3 inverse by adjugate: Q8.8 in, saturated Q16.16 out.
// ----------------------------------------------------------------------------
//
//  channel  | ports                      | direction | handshake
//  ---------+----------------------------+-----------+-----------------
//  input    | in_m00 .. in_m22           | in        | in_valid/in_stall
//  result   | out_r00..r22, singular/ovf | out       | out_valid/out_stall
//
//  One matrix per cycle, sustained while no result is held by out_stall. The
//  pipeline has 2 cofactor stages, 2 determinant stages, 8 divider stages
//  (4 quotient bits each, set by STEPS in mi3_pkg) and the output register.
//  Reset (rst_n low, synchronous) clears only the valid bits.
//  A stalled result freezes the whole pipeline; in_stall rises in that case.
//
`default_nettype none

module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  elem_t in_m00, input elem_t in_m01, input elem_t in_m02,
  input  elem_t in_m10, input elem_t in_m11, input elem_t in_m12,
  input  elem_t in_m20, input elem_t in_m21, input elem_t in_m22,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_r00, output res_t out_r01, output res_t out_r02,
  output res_t  out_r10, output res_t out_r11, output res_t out_r12,
  output res_t  out_r20, output res_t out_r21, output res_t out_r22,
  output logic  out_singular,
  output logic  out_overflow
);

  localparam int unsigned TAIL = DIV_STG + 1;

  logic              en;
  elem_arr_t         m;
  logic              cof_vld, det_vld;
  cof_arr_t          cof;
  elem_t             row0 [3];
  logic [DET_W-1:0]  det_mag;
  logic              det_zero;
  mag_arr_t          adj_mag;
  logic [NLANES-1:0] adj_neg;
  res_arr_t          quo;
  logic [NLANES-1:0] sat;
  logic [TAIL-1:0]   vld_r;
  logic [TAIL-1:0]   sng_r;
  logic              sng;

  // whole pipeline moves unless a finished transaction is being held
  assign en       = !vld_r[TAIL-1] || !out_stall;
  assign in_stall = !en;

  assign m = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  mi3_cofactor u_cof (
    .clk, .rst_n, .en,
    .in_vld (in_valid),
    .m,
    .out_vld(cof_vld),
    .cof,
    .row0
  );

  mi3_det u_det (
    .clk, .rst_n, .en,
    .in_vld  (cof_vld),
    .cof,
    .row0,
    .out_vld (det_vld),
    .det_mag,
    .det_zero,
    .adj_mag,
    .adj_neg
  );

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk, .en,
      .den  (det_mag),
      .amag (adj_mag[k]),
      .neg  (adj_neg[k]),
      .quo  (quo[k]),
      .sat  (sat[k])
    );
  end

  // valid and singular flag ride alongside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TAIL-2:0], det_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sng_r <= {sng_r[TAIL-2:0], det_zero};
    end
  end

  assign sng = sng_r[TAIL-1];

  // singular: all entries zero, no overflow
  assign out_valid    = vld_r[TAIL-1];
  assign out_singular = sng;
  assign out_overflow = !sng && (|sat);
  assign out_r00 = sng ? '0 : quo[0];
  assign out_r01 = sng ? '0 : quo[1];
  assign out_r02 = sng ? '0 : quo[2];
  assign out_r10 = sng ? '0 : quo[3];
  assign out_r11 = sng ? '0 : quo[4];
  assign out_r12 = sng ? '0 : quo[5];
  assign out_r20 = sng ? '0 : quo[6];
  assign out_r21 = sng ? '0 : quo[7];
  assign out_r22 = sng ? '0 : quo[8];

endmodule

`default_nettype wire
